FILE: sv/nsm_pkg.sv
// ---------------------------------------------------------------------------
// nsm_pkg
// Shared types and constants of the NFA subset matcher: table geometry,
// word formats of both channels, mode and register codes, and the control
// and status bundles between the sequencer and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package nsm_pkg;

  // automaton geometry
  localparam int NUM_STATES  = 32;
  localparam int NUM_SYMBOLS = 128;
  localparam int STATE_W     = $clog2(NUM_STATES);
  localparam int SYM_W       = $clog2(NUM_SYMBOLS);
  localparam int ROWS        = NUM_STATES * NUM_SYMBOLS;
  localparam int ADDR_W      = STATE_W + SYM_W;

  // configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MASK  = 1'b1;

  // one bit per state
  typedef logic [NUM_STATES-1:0] row_t;

  // operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_STEP = 2'd1,
    MODE_END  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_STEP,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // input word
  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] symbol;
    logic [4:0] src_state;
    logic [4:0] dst_state;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        accepted;
    logic [31:0] active_set;
    logic        string_done;
  } out_word_t;

  // sequencer to datapath
  typedef struct packed {
    logic               item_take;
    logic [1:0]         mode;
    logic               acc_en;
    logic [STATE_W-1:0] rd_state;
    logic               row_merge;
    logic [STATE_W-1:0] dst_state;
    logic               commit;
    logic               out_load;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/nsm_in_if.sv
// ---------------------------------------------------------------------------
// nsm_in_if
// Input channel of the NFA subset matcher: valid, ready and one input word.
// ---------------------------------------------------------------------------
`default_nettype none

interface nsm_in_if;
  logic               valid;
  logic               ready;
  nsm_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/nsm_out_if.sv
// ---------------------------------------------------------------------------
// nsm_out_if
// Result channel of the NFA subset matcher: valid, ready and one result word.
// ---------------------------------------------------------------------------
`default_nettype none

interface nsm_out_if;
  logic               valid;
  logic               ready;
  nsm_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/nfa_subset_matcher.sv
// ---------------------------------------------------------------------------
// nfa_subset_matcher
// NFA matcher by subset simulation over a table of destination-state masks.
// ---------------------------------------------------------------------------
// After reset the block sweeps the 4096-row transition table to zero, one
// row a cycle, and takes no word until that sweep is done; configuration
// writes are taken at any time. Every word gives one result word. A consume
// word (mode 1) goes through capture, 32 row reads (one per state,
// active or not) through the single table port, a step to fold in the
// last row, and the output load. Adding a transition (mode 0) reads the row
// and writes it back; end of string and the unused mode go to the load.
// A word is taken while the previous result still waits in the output
// register; its own result then waits until that register is free.
`default_nettype none

module nfa_subset_matcher (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  nsm_in_if.sink                             in_i,
  nsm_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [nsm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [nsm_pkg::CFG_W-1:0]     cfg_data_i
);

  nsm_pkg::ctrl_t             ctrl;
  nsm_pkg::stat_t             stat;
  logic [nsm_pkg::ADDR_W-1:0] ram_addr;
  logic                       ram_we;
  logic                       ram_zero;
  nsm_pkg::row_t              ram_rdata;
  nsm_pkg::row_t              ram_wdata;
  nsm_pkg::row_t              wr_row;

  // sequencer
  nsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .ram_addr_o (ram_addr),
    .ram_we_o   (ram_we),
    .ram_zero_o (ram_zero)
  );

  // transition table, zero rows during the clearing sweep
  assign ram_wdata = ram_zero ? '0 : wr_row;

  nsm_ram #(
    .WIDTH (nsm_pkg::NUM_STATES),
    .DEPTH (nsm_pkg::ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // datapath and output register
  nsm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .rdata_i     (ram_rdata),
    .wr_row_o    (wr_row),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

`default_nettype wire

FILE: sv/nsm_ram.sv
// ---------------------------------------------------------------------------
// nsm_ram
// Generic single-port RAM with one read/write address and registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module nsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/nsm_ctrl.sv
// ---------------------------------------------------------------------------
// nsm_ctrl
// Sequencer of the NFA subset matcher: clearing pass, item capture, table
// address generation, row read-modify-write and the per-state row sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module nsm_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire nsm_pkg::in_word_t          in_data_i,
  output      logic                       in_ready_o,
  input  wire nsm_pkg::stat_t             stat_i,
  output      nsm_pkg::ctrl_t             ctrl_o,
  output      logic [nsm_pkg::ADDR_W-1:0] ram_addr_o,
  output      logic                       ram_we_o,
  output      logic                       ram_zero_o
);

  nsm_pkg::state_e              state_q, state_d;
  logic [nsm_pkg::ADDR_W-1:0]   clr_q, clr_d;
  logic [nsm_pkg::STATE_W-1:0]  cnt_q, cnt_d;
  logic [nsm_pkg::STATE_W-1:0]  rd_st_q, rd_st_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [nsm_pkg::SYM_W-1:0]    sym_q;
  logic [nsm_pkg::STATE_W-1:0]  src_q;
  logic [nsm_pkg::STATE_W-1:0]  dst_q;
  logic                         take;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nsm_pkg::ST_CLEAR;
      clr_q    <= '0;
      cnt_q    <= '0;
      rd_st_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      rd_st_q  <= rd_st_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // captured word fields
  always_ff @(posedge clk_i) begin
    if (take) begin
      sym_q <= in_data_i.symbol;
      src_q <= in_data_i.src_state;
      dst_q <= in_data_i.dst_state;
    end
  end

  // next state and outputs
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    rd_st_d    = rd_st_q;
    rd_vld_d   = 1'b0;
    in_ready_o = 1'b0;
    take       = 1'b0;
    ram_addr_o = {src_q, sym_q};
    ram_we_o   = 1'b0;
    ram_zero_o = 1'b0;
    ctrl_o     = '0;

    unique case (state_q)
      // zero the table one row per cycle after reset
      nsm_pkg::ST_CLEAR: begin
        ram_addr_o = clr_q;
        ram_we_o   = 1'b1;
        ram_zero_o = 1'b1;
        clr_d      = clr_q + 1'b1;
        if (clr_q == nsm_pkg::ADDR_W'(nsm_pkg::ROWS - 1)) begin
          state_d = nsm_pkg::ST_IDLE;
        end
      end
      nsm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          take = 1'b1;
          case (nsm_pkg::mode_e'(in_data_i.mode))
            nsm_pkg::MODE_ADD: state_d = nsm_pkg::ST_ADD_RD;
            nsm_pkg::MODE_STEP: begin
              cnt_d   = '0;
              state_d = nsm_pkg::ST_STEP;
            end
            default: state_d = nsm_pkg::ST_EMIT;
          endcase
        end
      end
      // read the row of the new transition
      nsm_pkg::ST_ADD_RD: begin
        state_d = nsm_pkg::ST_ADD_WR;
      end
      // write it back with the destination bit set
      nsm_pkg::ST_ADD_WR: begin
        ram_we_o = 1'b1;
        state_d  = nsm_pkg::ST_EMIT;
      end
      // one row read per state, data comes back in the following cycle
      nsm_pkg::ST_STEP: begin
        ram_addr_o = {cnt_q, sym_q};
        rd_vld_d   = 1'b1;
        rd_st_d    = cnt_q;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == nsm_pkg::STATE_W'(nsm_pkg::NUM_STATES - 1)) begin
          state_d = nsm_pkg::ST_DRAIN;
        end
      end
      // last row merges and the new set is committed
      nsm_pkg::ST_DRAIN: begin
        ctrl_o.commit = 1'b1;
        state_d       = nsm_pkg::ST_EMIT;
      end
      // hand the result to the output register once it is free
      nsm_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = nsm_pkg::ST_IDLE;
        end
      end
      default: state_d = nsm_pkg::ST_IDLE;
    endcase

    ctrl_o.item_take = take;
    ctrl_o.mode      = in_data_i.mode;
    ctrl_o.acc_en    = rd_vld_q;
    ctrl_o.rd_state  = rd_st_q;
    ctrl_o.row_merge = (state_q == nsm_pkg::ST_ADD_WR);
    ctrl_o.dst_state = dst_q;
  end

endmodule

`default_nettype wire

FILE: sv/nsm_dp.sv
// ---------------------------------------------------------------------------
// nsm_dp
// Datapath of the NFA subset matcher: configuration registers, active set,
// the shared row merge unit, result flags and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module nsm_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [nsm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [nsm_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire nsm_pkg::ctrl_t                ctrl_i,
  input  wire nsm_pkg::row_t                 rdata_i,
  output      nsm_pkg::row_t                 wr_row_o,
  output      nsm_pkg::stat_t                stat_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      nsm_pkg::out_word_t            out_data_o
);

  nsm_pkg::row_t      accept_mask_q;
  nsm_pkg::row_t      start_mask_q;
  nsm_pkg::row_t      active_q;
  nsm_pkg::row_t      acc_q;
  logic               acc_flag_q;
  logic               done_q;
  logic               out_valid_q;
  nsm_pkg::out_word_t out_data_q;
  nsm_pkg::row_t      or_a;
  nsm_pkg::row_t      or_b;
  nsm_pkg::row_t      or_res;
  logic               is_end;

  assign is_end = (ctrl_i.mode == nsm_pkg::MODE_END);

  // shared merge unit: set a destination bit or fold in a state's row
  always_comb begin
    if (ctrl_i.row_merge) begin
      or_a = rdata_i;
      or_b = nsm_pkg::row_t'(1) << ctrl_i.dst_state;
    end else begin
      or_a = acc_q;
      or_b = active_q[ctrl_i.rd_state] ? rdata_i : '0;
    end
    or_res = or_a | or_b;
  end

  assign wr_row_o = or_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_mask_q <= '0;
      start_mask_q  <= nsm_pkg::row_t'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nsm_pkg::REG_ACCEPT_MASK: accept_mask_q <= cfg_data_i[nsm_pkg::NUM_STATES-1:0];
        nsm_pkg::REG_START_MASK:  start_mask_q  <= cfg_data_i[nsm_pkg::NUM_STATES-1:0];
        default: ;
      endcase
    end
  end

  // active set, row accumulator and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= nsm_pkg::row_t'(1);
      acc_q      <= '0;
      acc_flag_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (ctrl_i.item_take) begin
        acc_q      <= '0;
        acc_flag_q <= is_end && ((active_q & accept_mask_q) != '0);
        done_q     <= is_end;
      end else if (ctrl_i.acc_en) begin
        acc_q <= or_res;
      end
      if (ctrl_i.item_take && is_end) begin
        active_q <= start_mask_q;
      end else if (ctrl_i.commit) begin
        active_q <= or_res;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_data_q.accepted    <= acc_flag_q;
      out_data_q.active_set  <= 32'(active_q);
      out_data_q.string_done <= done_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

`default_nettype wire

FILE: sv/nsm_checker.sv
// ---------------------------------------------------------------------------
// nsm_checker
// Port-level checks of the NFA subset matcher, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module nsm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_accepted_i,
  input wire logic out_string_done_i
);

  // a pending result word stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // one word at a time: no new word right after one is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high right after a word was taken");

  // acceptance is only reported when a string closes
  a_acc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_accepted_i |-> out_string_done_i)
    else $error("accepted without string_done");

  // no result appears in the cycle right after a word is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

endmodule

bind nfa_subset_matcher nsm_checker u_nsm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_accepted_i    (out_o.data.accepted),
  .out_string_done_i (out_o.data.string_done)
);

`default_nettype wire

FILE: tb/sv/nfa_subset_matcher_tb.sv
// ---------------------------------------------------------------------------
// nfa_subset_matcher_tb
// Self-checking bench for the NFA subset matcher. A short table of directed
// words (empty table, corner states and symbols, every mode, acceptance and
// start reload) runs first, then random automata and strings over a small
// per-phase alphabet under several accept/start settings and flow-control
// mixes. Results are checked against the table word or a bit-set NFA model.
// ---------------------------------------------------------------------------
module nfa_subset_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsm_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 171;
  localparam int DRAIN_CYCLES  = 40;
  localparam int DIR_ROWS      = 24;

  typedef struct {
    mode_e     mode;
    logic [6:0] sym;
    logic [4:0] src;
    logic [4:0] dst;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  nsm_in_if  in_if ();
  nsm_out_if out_if ();

  nfa_subset_matcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // model state of the automaton
  row_t trans_rows [ROWS];
  row_t live_set;
  row_t accept_reg;
  row_t start_reg;

  out_word_t pending_matches [$];
  int err_count = 0;
  int send_idle_pct = 0;
  int ready_stall_pct = 0;
  int cycle_count = 0;

  logic [6:0] alphabet [4];
  logic [4:0] state_pool [6];

  // directed words, accept mask 8000_0000 and start mask 1 while they run
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{MODE_NOP,  7'd127, 5'd31, 5'd31, 1'b1, '{1'b0, 32'h0000_0001, 1'b0}},
    '{MODE_STEP, 7'd0,   5'd0,  5'd0,  1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{MODE_NOP,  7'd0,   5'd0,  5'd0,  1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{MODE_END,  7'd0,   5'd0,  5'd0,  1'b1, '{1'b0, 32'h0000_0001, 1'b1}},
    '{MODE_ADD,  7'd127, 5'd0,  5'd31, 1'b1, '{1'b0, 32'h0000_0001, 1'b0}},
    '{MODE_ADD,  7'd127, 5'd31, 5'd0,  1'b1, '{1'b0, 32'h0000_0001, 1'b0}},
    '{MODE_ADD,  7'd0,   5'd31, 5'd31, 1'b1, '{1'b0, 32'h0000_0001, 1'b0}},
    '{MODE_STEP, 7'd127, 5'd0,  5'd0,  1'b1, '{1'b0, 32'h8000_0000, 1'b0}},
    '{MODE_END,  7'd0,   5'd0,  5'd0,  1'b1, '{1'b1, 32'h0000_0001, 1'b1}},
    '{MODE_STEP, 7'd127, 5'd0,  5'd0,  1'b1, '{1'b0, 32'h8000_0000, 1'b0}},
    '{MODE_STEP, 7'd127, 5'd0,  5'd0,  1'b1, '{1'b0, 32'h0000_0001, 1'b0}},
    '{MODE_STEP, 7'd127, 5'd0,  5'd0,  1'b1, '{1'b0, 32'h8000_0000, 1'b0}},
    '{MODE_STEP, 7'd0,   5'd0,  5'd0,  1'b1, '{1'b0, 32'h8000_0000, 1'b0}},
    '{MODE_STEP, 7'd0,   5'd0,  5'd0,  1'b1, '{1'b0, 32'h8000_0000, 1'b0}},
    '{MODE_END,  7'd0,   5'd0,  5'd0,  1'b1, '{1'b1, 32'h0000_0001, 1'b1}},
    '{MODE_ADD,  7'd85,  5'd0,  5'd10, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_ADD,  7'd85,  5'd0,  5'd21, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_ADD,  7'd42,  5'd10, 5'd31, 1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_ADD,  7'd42,  5'd21, 5'd5,  1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_STEP, 7'd85,  5'd0,  5'd0,  1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_STEP, 7'd42,  5'd0,  5'd0,  1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_END,  7'd0,   5'd0,  5'd0,  1'b0, '{1'b0, 32'h0, 1'b0}},
    '{MODE_STEP, 7'd64,  5'd0,  5'd0,  1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
    '{MODE_END,  7'd0,   5'd0,  5'd0,  1'b1, '{1'b0, 32'h0000_0001, 1'b1}}
  };

  // clock, low first so the first rising edge comes after time zero
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one word through the automaton: table insert, symbol step or string end
  function automatic out_word_t advance_nfa(in_word_t w);
    out_word_t r;
    row_t nxt;
    int s;
    r = '0;
    case (mode_e'(w.mode))
      MODE_ADD: begin
        trans_rows[{w.src_state, w.symbol}] |= row_t'(1) << w.dst_state;
      end
      MODE_STEP: begin
        nxt = '0;
        for (s = 0; s < NUM_STATES; s++) begin
          if (live_set[s]) nxt |= trans_rows[{5'(s), w.symbol}];
        end
        live_set = nxt;
      end
      MODE_END: begin
        r.accepted = |(live_set & accept_reg);
        r.string_done = 1'b1;
        live_set = start_reg;
      end
      default: ;
    endcase
    r.active_set = live_set;
    return r;
  endfunction

  // mostly states from this phase's pool so strings get somewhere
  function automatic logic [4:0] pick_state();
    if ($urandom_range(99) < 80) return state_pool[$urandom_range(5)];
    return 5'($urandom_range(31));
  endfunction

  // queue the expectation, then offer the word until it is taken
  task automatic issue(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t exp_word;
    exp_word = advance_nfa(w);
    if (typed) exp_word = want;
    pending_matches.push_back(exp_word);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // stop offering words and let every result come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
  endtask

  // both registers, back to back
  task automatic write_masks(input logic [31:0] acc, input logic [31:0] start);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_ACCEPT_MASK;
    cfg_data_i <= acc;
    @(posedge clk_i);
    accept_reg = acc;
    cfg_idx_i <= REG_START_MASK;
    cfg_data_i <= start;
    @(posedge clk_i);
    start_reg = start;
    cfg_we_i <= 1'b0;
  endtask

  // result side: random back-pressure and compare against oldest expectation
  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t exp_word;
    if (out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected word, got acc=%0b set=%h done=%0b", $time,
                 got.accepted, got.active_set, got.string_done);
        err_count++;
      end else begin
        exp_word = pending_matches.pop_front();
        if (got.accepted !== exp_word.accepted) begin
          $display("%0t: accepted mismatch, expected %0b, got %0b", $time,
                   exp_word.accepted, got.accepted);
          err_count++;
        end
        if (got.active_set !== exp_word.active_set) begin
          $display("%0t: active_set mismatch, expected %h, got %h", $time,
                   exp_word.active_set, got.active_set);
          err_count++;
        end
        if (got.string_done !== exp_word.string_done) begin
          $display("%0t: string_done mismatch, expected %0b, got %0b", $time,
                   exp_word.string_done, got.string_done);
          err_count++;
        end
      end
    end
    out_if.ready <= !(ready_stall_pct != 0 && $urandom_range(99) < ready_stall_pct);
  end

  // stimulus
  initial begin
    in_word_t w;
    out_word_t none;
    logic [31:0] acc;
    logic [31:0] start;
    int pick;
    int s;

    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_ACCEPT_MASK;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;

    for (s = 0; s < ROWS; s++) trans_rows[s] = '0;
    accept_reg = '0;
    start_reg = row_t'(1);
    live_set = row_t'(1);
    none = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    write_masks(32'h8000_0000, 32'h0000_0001);
    foreach (dir_tab[i]) begin
      w.mode = dir_tab[i].mode;
      w.symbol = dir_tab[i].sym;
      w.src_state = dir_tab[i].src;
      w.dst_state = dir_tab[i].dst;
      issue(w, dir_tab[i].typed, dir_tab[i].want);
    end
    drain_results();

    // random automata and strings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin acc = 32'hFFFF_FFFF; start = 32'hFFFF_FFFF; end
        1: begin acc = 32'h0000_0000; start = 32'h0000_0000; end
        2: begin acc = $urandom;      start = $urandom;      end
        3: begin acc = 32'h0000_0001; start = 32'h8000_0000; end
        4: begin acc = $urandom;      start = 32'h0000_0001; end
        default: begin acc = 32'h8000_0000; start = $urandom; end
      endcase
      write_masks(acc, start);

      case (ph)
        1: begin send_idle_pct = 71; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 71; end
        3: begin send_idle_pct = 12; ready_stall_pct = 12; end
        5: begin send_idle_pct = 0;  ready_stall_pct = 71; end
        default: begin send_idle_pct = 0; ready_stall_pct = 0; end
      endcase

      foreach (alphabet[k]) alphabet[k] = 7'($urandom_range(127));
      foreach (state_pool[k]) state_pool[k] = 5'($urandom_range(31));
      // with a non-empty start mask one pool state is a start state, so the first step has a way out
      for (s = 31; s >= 0; s--) begin
        if (start[s]) state_pool[0] = 5'(s);
      end

      repeat (PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 25) w.mode = MODE_ADD;
        else if (pick < 75) w.mode = MODE_STEP;
        else if (pick < 95) w.mode = MODE_END;
        else w.mode = MODE_NOP;
        if ($urandom_range(99) < 85) w.symbol = alphabet[$urandom_range(3)];
        else w.symbol = 7'($urandom_range(127));
        w.src_state = pick_state();
        w.dst_state = pick_state();
        issue(w, 1'b0, none);
      end
      drain_results();
    end

    send_idle_pct = 0;
    ready_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0 && pending_matches.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
